FILE: rtl/lrupfm_pkg.sv
// ----------------------------------------------------------------------------
// lrupfm_pkg
// Shared types and constants for the LRU page frame manager.
// ----------------------------------------------------------------------------
package lrupfm_pkg;

  localparam int NumFrames = 16;
  localparam int FileBits  = 8;
  localparam int PageBits  = 32;
  localparam int IdxBits   = 4;
  localparam int LimBits   = 5;

  localparam logic [2:0] FuncFetch = 3'd0;
  localparam logic [2:0] FuncUnpin = 3'd1;
  localparam logic [2:0] FuncDirty = 3'd2;
  localparam logic [2:0] FuncFlush = 3'd3;
  localparam logic [2:0] FuncFlushAll = 3'd4;

  localparam logic [1:0] ActDone  = 2'd0;
  localparam logic [1:0] ActWrite = 2'd1;
  localparam logic [1:0] ActRead  = 2'd2;

  localparam logic [2:0] StHitOk      = 3'd0;
  localparam logic [2:0] StMissLoaded = 3'd1;
  localparam logic [2:0] StAllPinned  = 3'd2;
  localparam logic [2:0] StNotPresent = 3'd3;
  localparam logic [2:0] StUnpinned   = 3'd4;
  localparam logic [2:0] StNothing    = 3'd5;

  // Result emit selection from controller to datapath.
  typedef enum logic [2:0] {
    EmitHit, EmitAllPinned, EmitVictimWb, EmitLoad, EmitSimple,
    EmitFlushWb, EmitFlushDone, EmitBad
  } emit_t;

  // Commands from controller to datapath.
  typedef struct packed {
    logic  capture;    // latch request, run search
    logic  do_hit;     // pin + make recent + hit count
    logic  do_miss;    // miss count
    logic  do_load;    // install new page at victim
    logic  do_simple;  // unpin / dirty / flush page update
    logic  do_flush_wb; // clear dirty at scan index
    logic  scan_clr;
    logic  scan_inc;
    logic  emit;
    emit_t emit_sel;
  } cmd_t;

  // Status from datapath to controller.
  typedef struct packed {
    logic [2:0] func;
    logic       found;
    logic       victim_ok;
    logic       victim_dirty;
    logic       scan_dirty;
    logic       scan_end;
    logic       out_busy;
  } stat_t;

endpackage

FILE: rtl/lrupfm_ctrl.sv
// ----------------------------------------------------------------------------
// lrupfm_ctrl
// Request sequencer: steps each request through search, update and results.
// ----------------------------------------------------------------------------
module lrupfm_ctrl (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_fire,
  input  lrupfm_pkg::stat_t   st,
  output logic                idle,
  output lrupfm_pkg::cmd_t    cmd
);

  typedef enum logic [2:0] {
    S_IDLE, S_SEARCH, S_DECIDE, S_LOAD, S_SCAN, S_DONE
  } state_t;

  state_t state;

  assign idle = (state == S_IDLE);

  always_comb begin
    cmd = '0;
    cmd.emit_sel = lrupfm_pkg::EmitBad;
    cmd.capture = in_fire;
    unique case (state)
      S_IDLE: ;
      S_SEARCH: ;
      S_DECIDE: begin
        if (!st.out_busy) begin
          if (st.func == lrupfm_pkg::FuncFetch) begin
            if (st.found) begin
              cmd.do_hit = 1'b1; cmd.emit = 1'b1;
              cmd.emit_sel = lrupfm_pkg::EmitHit;
            end else if (!st.victim_ok) begin
              cmd.do_miss = 1'b1; cmd.emit = 1'b1;
              cmd.emit_sel = lrupfm_pkg::EmitAllPinned;
            end else begin
              cmd.do_miss = 1'b1;
              if (st.victim_dirty) begin
                cmd.emit = 1'b1;
                cmd.emit_sel = lrupfm_pkg::EmitVictimWb;
              end
            end
          end else if (st.func == lrupfm_pkg::FuncFlushAll) begin
            cmd.scan_clr = 1'b1;
          end else if (st.func > lrupfm_pkg::FuncFlushAll) begin
            cmd.emit = 1'b1; cmd.emit_sel = lrupfm_pkg::EmitBad;
          end else begin
            cmd.do_simple = 1'b1; cmd.emit = 1'b1;
            cmd.emit_sel = lrupfm_pkg::EmitSimple;
          end
        end
      end
      S_LOAD: begin
        if (!st.out_busy) begin
          cmd.do_load = 1'b1; cmd.emit = 1'b1;
          cmd.emit_sel = lrupfm_pkg::EmitLoad;
        end
      end
      S_SCAN: begin
        if (!st.scan_end) begin
          if (st.scan_dirty) begin
            if (!st.out_busy) begin
              cmd.do_flush_wb = 1'b1; cmd.emit = 1'b1;
              cmd.emit_sel = lrupfm_pkg::EmitFlushWb;
              cmd.scan_inc = 1'b1;
            end
          end else begin
            cmd.scan_inc = 1'b1;
          end
        end
      end
      S_DONE: begin
        if (!st.out_busy) begin
          cmd.emit = 1'b1; cmd.emit_sel = lrupfm_pkg::EmitFlushDone;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      unique case (state)
        S_IDLE:   if (in_fire) state <= S_SEARCH;
        S_SEARCH: state <= S_DECIDE;
        S_DECIDE: begin
          if (!st.out_busy) begin
            if (st.func == lrupfm_pkg::FuncFetch && !st.found && st.victim_ok)
              state <= S_LOAD;
            else if (st.func == lrupfm_pkg::FuncFlushAll)
              state <= S_SCAN;
            else
              state <= S_IDLE;
          end
        end
        S_LOAD: if (!st.out_busy) state <= S_IDLE;
        S_SCAN: if (st.scan_end) state <= S_DONE;
        S_DONE: if (!st.out_busy) state <= S_IDLE;
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule

FILE: rtl/lrupfm_dp.sv
// ----------------------------------------------------------------------------
// lrupfm_dp
// Frame table, key search, victim choice, counters and result register.
// ----------------------------------------------------------------------------
module lrupfm_dp (
  input  logic                 clk,
  input  logic                 rst,
  input  lrupfm_pkg::cmd_t     cmd,
  output lrupfm_pkg::stat_t    st,
  input  logic [2:0]           func,
  input  logic [7:0]           file_id,
  input  logic [31:0]          page_num,
  input  logic [4:0]           frames_in_use,
  output logic                 valid,
  input  logic                 ready,
  output logic [1:0]           action,
  output logic [3:0]           frame_index,
  output logic [7:0]           out_file_id,
  output logic [31:0]          out_page_num,
  output logic [2:0]           status,
  output logic [15:0]          pins_held,
  output logic [31:0]          hit_total,
  output logic [31:0]          miss_total,
  output logic                 last
);

  localparam int N  = lrupfm_pkg::NumFrames;
  localparam int IB = lrupfm_pkg::IdxBits;
  localparam int LB = lrupfm_pkg::LimBits;

  logic [N-1:0]                   fvalid, fdirty;
  logic [15:0]                    fpins [N];
  logic [lrupfm_pkg::FileBits-1:0] ffile [N];
  logic [lrupfm_pkg::PageBits-1:0] fpage [N];
  logic [IB-1:0]                  frank [N];
  logic [31:0]                    hits, misses;

  logic [2:0]  rq_func;
  logic [7:0]  rq_file;
  logic [31:0] rq_page;
  logic [LB-1:0] lim;

  // search results, registered
  logic          found;
  logic [IB-1:0] hit_idx;
  logic          vic_ok;
  logic [IB-1:0] vic_idx;
  logic [LB-1:0] scan;

  // usable frame limit
  always_comb begin
    if (frames_in_use == '0) lim = LB'(1);
    else if (frames_in_use > LB'(N)) lim = LB'(N);
    else lim = frames_in_use;
  end

  // combinational search over the frame tags
  logic          s_found;
  logic [IB-1:0] s_hit;
  logic          s_inv;
  logic [IB-1:0] s_inv_idx;
  logic          s_lru;
  logic [IB-1:0] s_lru_idx;
  logic [N-1:0]  lru_cand;
  logic [N-1:0]  lru_max;

  always_comb begin
    s_found = 1'b0; s_hit = '0;
    s_inv = 1'b0; s_inv_idx = '0;
    s_lru = 1'b0; s_lru_idx = '0;
    for (int i = N - 1; i >= 0; i--) begin
      if (LB'(i) < lim) begin
        if (fvalid[i] && ffile[i] == rq_file[lrupfm_pkg::FileBits-1:0] &&
            fpage[i] == rq_page[lrupfm_pkg::PageBits-1:0]) begin
          s_found = 1'b1; s_hit = IB'(i);
        end
        if (!fvalid[i]) begin
          s_inv = 1'b1; s_inv_idx = IB'(i);
        end
      end
    end
    // oldest unpinned frame: pairwise rank compare, lower index wins a tie
    for (int i = 0; i < N; i++) lru_cand[i] = (LB'(i) < lim) && (fpins[i] == '0);
    for (int i = 0; i < N; i++) begin
      lru_max[i] = lru_cand[i];
      for (int j = 0; j < N; j++) begin
        if (lru_cand[j] && (frank[j] > frank[i] || (frank[j] == frank[i] && j < i)))
          lru_max[i] = 1'b0;
      end
    end
    s_lru = |lru_cand;
    for (int i = 0; i < N; i++) begin
      if (lru_max[i]) s_lru_idx = IB'(i);
    end
  end

  logic [IB-1:0] sc_idx;
  assign sc_idx = scan[IB-1:0];

  assign st.func         = rq_func;
  assign st.found        = found;
  assign st.victim_ok    = vic_ok;
  assign st.victim_dirty = fvalid[vic_idx] && fdirty[vic_idx];
  assign st.scan_end     = (scan >= lim);
  assign st.scan_dirty   = fvalid[sc_idx] && fdirty[sc_idx];
  assign st.out_busy     = valid && !ready;

  // target frame of recency update
  logic          mr_en;
  logic [IB-1:0] mr_f;
  assign mr_en = cmd.do_hit || cmd.do_load;
  assign mr_f  = cmd.do_hit ? hit_idx : vic_idx;

  logic [15:0] pins_f;
  assign pins_f = fpins[hit_idx];

  always_ff @(posedge clk) begin
    if (rst) begin
      fvalid <= '0;
      fdirty <= '0;
      hits   <= '0;
      misses <= '0;
      scan   <= '0;
      found  <= 1'b0;
      vic_ok <= 1'b0;
      for (int i = 0; i < N; i++) begin
        fpins[i] <= '0;
        frank[i] <= '0;
      end
    end else begin
      if (cmd.capture) begin
        rq_func <= func;
        rq_file <= file_id;
        rq_page <= page_num;
      end
      // registered search over the captured request
      found   <= s_found;
      hit_idx <= s_hit;
      vic_ok  <= s_inv || s_lru;
      vic_idx <= s_inv ? s_inv_idx : s_lru_idx;

      if (cmd.scan_clr) scan <= '0;
      else if (cmd.scan_inc) scan <= scan + LB'(1);

      if (cmd.do_hit) hits <= hits + 32'd1;
      if (cmd.do_miss) misses <= misses + 32'd1;

      if (mr_en) begin
        for (int j = 0; j < N; j++) begin
          if (IB'(j) != mr_f && fvalid[j] &&
              (!fvalid[mr_f] || frank[j] < frank[mr_f]))
            frank[j] <= frank[j] + IB'(1);
        end
        frank[mr_f]  <= '0;
        fvalid[mr_f] <= 1'b1;
      end
      if (cmd.do_hit && pins_f != 16'hFFFF) fpins[hit_idx] <= pins_f + 16'd1;
      if (cmd.do_load) begin
        ffile[vic_idx]  <= rq_file[lrupfm_pkg::FileBits-1:0];
        fpage[vic_idx]  <= rq_page[lrupfm_pkg::PageBits-1:0];
        fpins[vic_idx]  <= 16'd1;
        fdirty[vic_idx] <= 1'b0;
      end
      if (cmd.do_simple && found) begin
        unique case (rq_func)
          lrupfm_pkg::FuncUnpin: if (pins_f != '0) fpins[hit_idx] <= pins_f - 16'd1;
          lrupfm_pkg::FuncDirty: fdirty[hit_idx] <= 1'b1;
          default: fdirty[hit_idx] <= 1'b0;
        endcase
      end
      if (cmd.do_flush_wb) fdirty[sc_idx] <= 1'b0;
    end
  end

  // result register
  logic          any_wb;
  logic [31:0]   hits_n, misses_n;
  logic [1:0]    action_next;
  logic [IB-1:0] frame_next;
  logic [7:0]    file_next;
  logic [31:0]   page_next;
  logic [2:0]    status_next;
  logic [15:0]   pins_next;
  logic          last_next;

  assign hits_n   = cmd.do_hit ? hits + 32'd1 : hits;
  assign misses_n = cmd.do_miss ? misses + 32'd1 : misses;

  always_comb begin
    action_next = lrupfm_pkg::ActDone;
    frame_next  = '0;
    file_next   = rq_file;
    page_next   = rq_page;
    status_next = lrupfm_pkg::StHitOk;
    pins_next   = '0;
    last_next   = 1'b1;
    unique case (cmd.emit_sel)
      lrupfm_pkg::EmitHit: begin
        frame_next = hit_idx;
        pins_next  = (pins_f != 16'hFFFF) ? pins_f + 16'd1 : pins_f;
      end
      lrupfm_pkg::EmitAllPinned: status_next = lrupfm_pkg::StAllPinned;
      lrupfm_pkg::EmitVictimWb: begin
        action_next = lrupfm_pkg::ActWrite;
        frame_next  = vic_idx;
        file_next   = 8'(ffile[vic_idx]);
        page_next   = 32'(fpage[vic_idx]);
        status_next = lrupfm_pkg::StMissLoaded;
        pins_next   = fpins[vic_idx];
        last_next   = 1'b0;
      end
      lrupfm_pkg::EmitLoad: begin
        action_next = lrupfm_pkg::ActRead;
        frame_next  = vic_idx;
        status_next = lrupfm_pkg::StMissLoaded;
        pins_next   = 16'd1;
      end
      lrupfm_pkg::EmitSimple: begin
        if (!found) begin
          status_next = lrupfm_pkg::StNotPresent;
        end else begin
          frame_next = hit_idx;
          pins_next  = pins_f;
          unique case (rq_func)
            lrupfm_pkg::FuncUnpin: begin
              if (pins_f == '0) status_next = lrupfm_pkg::StUnpinned;
              else pins_next = pins_f - 16'd1;
            end
            lrupfm_pkg::FuncDirty: ;
            default: begin
              if (fdirty[hit_idx]) action_next = lrupfm_pkg::ActWrite;
              else status_next = lrupfm_pkg::StNothing;
            end
          endcase
        end
      end
      lrupfm_pkg::EmitFlushWb: begin
        action_next = lrupfm_pkg::ActWrite;
        frame_next  = sc_idx;
        file_next   = 8'(ffile[sc_idx]);
        page_next   = 32'(fpage[sc_idx]);
        pins_next   = fpins[sc_idx];
        last_next   = 1'b0;
      end
      lrupfm_pkg::EmitFlushDone: begin
        file_next   = '0;
        page_next   = '0;
        status_next = any_wb ? lrupfm_pkg::StHitOk : lrupfm_pkg::StNothing;
      end
      default: begin
        file_next   = '0;
        page_next   = '0;
        status_next = lrupfm_pkg::StNotPresent;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      valid  <= 1'b0;
      any_wb <= 1'b0;
    end else begin
      if (cmd.scan_clr) any_wb <= 1'b0;
      else if (cmd.emit && cmd.emit_sel == lrupfm_pkg::EmitFlushWb) any_wb <= 1'b1;
      if (cmd.emit) begin
        valid        <= 1'b1;
        hit_total    <= hits_n;
        miss_total   <= misses_n;
        last         <= last_next;
        action       <= action_next;
        frame_index  <= frame_next;
        out_file_id  <= file_next;
        out_page_num <= page_next;
        pins_held    <= pins_next;
        status       <= status_next;
      end else if (ready) begin
        valid <= 1'b0;
      end
    end
  end

endmodule

FILE: rtl/lru_page_frame_manager_unit.sv
// ----------------------------------------------------------------------------
// lru_page_frame_manager_unit
// LRU page frame manager with pin counts: fetch, unpin, mark dirty, flush.
// ----------------------------------------------------------------------------
// A miss with a dirty victim gives two results: the victim write-back, then
//   the load. A request is taken only while the unit is idle, and a result
//   waits while the output register is still full. Frame search is registered.
// Reset (synchronous rst): all frames invalid, clean, unpinned, counters 0,
//   frames_in_use = 16. No clearing pass is needed.
module lru_page_frame_manager_unit (
  input  logic        clk,
  input  logic        rst,
  // request channel
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [2:0]  func,
  input  logic [7:0]  file_id,
  input  logic [31:0] page_num,
  // result channel
  output logic        out_valid,
  input  logic        out_ready,
  output logic [1:0]  action,
  output logic [3:0]  frame_index,
  output logic [7:0]  out_file_id,
  output logic [31:0] out_page_num,
  output logic [2:0]  status,
  output logic [15:0] pins_held,
  output logic [31:0] hit_total,
  output logic [31:0] miss_total,
  output logic        last,
  // APB config
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [1:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  lrupfm_pkg::cmd_t  cmd;
  lrupfm_pkg::stat_t st;
  logic              idle;
  logic [4:0]        frames_in_use;

  // one register at address 0
  assign pready = 1'b1;
  assign prdata = (paddr == 2'd0) ? {27'd0, frames_in_use} : 32'd0;

  always_ff @(posedge clk) begin
    if (rst) begin
      frames_in_use <= 5'd16;
    end else if (psel && penable && pwrite && paddr == 2'd0) begin
      frames_in_use <= pwdata[4:0];
    end
  end

  // one request at a time; the result register decouples the output side
  assign in_ready = idle;

  lrupfm_ctrl u_ctrl (
    .clk     (clk),
    .rst     (rst),
    .in_fire (in_valid && in_ready),
    .st      (st),
    .idle    (idle),
    .cmd     (cmd)
  );

  lrupfm_dp u_dp (
    .clk           (clk),
    .rst           (rst),
    .cmd           (cmd),
    .st            (st),
    .func          (func),
    .file_id       (file_id),
    .page_num      (page_num),
    .frames_in_use (frames_in_use),
    .valid         (out_valid),
    .ready         (out_ready),
    .action        (action),
    .frame_index   (frame_index),
    .out_file_id   (out_file_id),
    .out_page_num  (out_page_num),
    .status        (status),
    .pins_held     (pins_held),
    .hit_total     (hit_total),
    .miss_total    (miss_total),
    .last          (last)
  );

endmodule
